/* design/ipn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipn_pkg: shared types and constants for the 3D gradient noise block
// Sequencer states, step codes, register map and fixed curve constants.
// ----------------------------------------------------------------------------
package ipn_pkg;

  localparam int unsigned CellBits = 8;

  // Fade curve 6t^5 - 15t^4 + 10t^3, Horner form t^3 * (t * (6t - 15) + 10)
  localparam int unsigned FadeC15 = 15;
  localparam int unsigned FadeC10 = 10;

  // Gradient codes that take x as the second term
  localparam logic [3:0] GradSwapA = 4'd12;
  localparam logic [3:0] GradSwapB = 4'd14;

  // Output range, Q2.16
  localparam int OutMax = 131071;
  localparam int OutMin = -131072;

  // Register map, index = paddr[3:2]
  localparam logic [1:0] RegOffsetX = 2'd0;
  localparam logic [1:0] RegOffsetY = 2'd1;
  localparam logic [1:0] RegOffsetZ = 2'd2;

  localparam int unsigned OffsetBits = 24;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_RUN  = 2'b10
  } fsm_e;

  // One code per cycle of an evaluation; STP_DONE holds until the output register frees up
  typedef enum logic [4:0] {
    STP_X2   = 5'd0,   // x*x
    STP_Y2   = 5'd1,
    STP_Z2   = 5'd2,
    STP_XI   = 5'd3,   // x*(6x-15)
    STP_YI   = 5'd4,
    STP_ZI   = 5'd5,
    STP_X3   = 5'd6,   // x^2*x
    STP_Y3   = 5'd7,
    STP_Z3   = 5'd8,
    STP_FX   = 5'd9,   // x^3*inner
    STP_FY   = 5'd10,
    STP_FZ   = 5'd11,
    STP_L0   = 5'd12,  // first row of x lerps
    STP_L2   = 5'd13,
    STP_L1   = 5'd14,
    STP_L3   = 5'd15,
    STP_L4   = 5'd16,  // y lerps
    STP_L5   = 5'd17,
    STP_GAP  = 5'd18,
    STP_L6   = 5'd19,  // z lerp
    STP_DONE = 5'd20
  } step_e;

endpackage
`default_nettype wire

/* design/ipn_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipn_ram: generic single-port RAM
// One address per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module ipn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(Depth)-1:0]  addr_i,
  input  wire  [Width-1:0]          wdata_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

/* design/ipn_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipn_mul: shared fixed-point multiplier
// Signed product scaled back by a flooring shift, result registered.
// ----------------------------------------------------------------------------
module ipn_mul #(
  parameter int unsigned Width    = 21,
  parameter int unsigned FracBits = 16
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire  signed [Width-1:0]  a_i,
  input  wire  signed [Width-1:0]  b_i,
  output logic signed [Width-1:0]  p_o
);

  logic signed [2*Width-1:0] prod;

  assign prod = a_i * b_i;

  // Hold the last product while idle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= Width'(prod >>> FracBits);
    end
  end

endmodule
`default_nettype wire

/* design/improved_perlin_noise_3d.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// improved_perlin_noise_3d: fixed-point 3D gradient noise evaluator
// Permutation-table lookup chain and fade/lerp math on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser = action. action 1 loads one permutation
//   entry (entry_index, entry_value) and yields no result.
//   action 0 evaluates noise at (coord_x, coord_y, coord_z) plus the offsets
//   set over the APB port, and yields one noise_value on m_axis.
//   Load all 256 table entries before the first evaluation.
//   Timing: an evaluation steps through the sequencer from its transfer to
//   its result appearing on m_axis; s_axis_tready is low throughout, so a
//   new item is taken only after the previous evaluation has finished. The
//   step sequence is set by the 19 products that all pass through the one
//   multiplier, plus a wait step for the last lerp operand and the output
//   step, with the 14 chained table reads on the single RAM port alongside.
//   Stall: the result sits in an output register; the next item is taken
//   while it waits. An evaluation that finishes while the previous result is
//   still untaken holds in its last step until m_axis_tready.
//   Reset: offsets clear to zero, the sequencer idles, no result is pending.
//   The table contents are not cleared.
//   The user must write offsets only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module improved_perlin_noise_3d #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  // s_axis tdata, lsb up: coord_x[31:0], coord_y[63:32], coord_z[95:64],
  //   entry_index[103:96], entry_value[111:104]
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [111:0] s_axis_tdata,
  // s_axis tuser: action[0]
  input  wire  [0:0]   s_axis_tuser,
  // m_axis tdata, lsb up: noise_value[17:0], zero pad [23:18]
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [23:0]  m_axis_tdata,
  // APB configuration port
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [3:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  import ipn_pkg::*;

  // Inner values span roughly (-16, 16) with FRAC_BITS fraction bits
  localparam int unsigned W = FRAC_BITS + 5;
  localparam logic signed [W-1:0] OneFx = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] C15Fx = W'(FadeC15) << FRAC_BITS;
  localparam logic signed [W-1:0] C10Fx = W'(FadeC10) << FRAC_BITS;
  localparam int unsigned RW = W + 16;

  // --------------------------------------------------------------------------
  // Gradient: pick two of x, y, z by the low hash bits and apply signs
  // --------------------------------------------------------------------------
  function automatic logic signed [W-1:0] grad(
    input logic [3:0]          h,
    input logic signed [W-1:0] gx,
    input logic signed [W-1:0] gy,
    input logic signed [W-1:0] gz
  );
    logic signed [W-1:0] gu;
    logic signed [W-1:0] gv;
    gu = (h < 4'd8) ? gx : gy;
    if (h < 4'd4) begin
      gv = gy;
    end else if (h == GradSwapA || h == GradSwapB) begin
      gv = gx;
    end else begin
      gv = gz;
    end
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [OffsetBits-1:0] off_q [3];
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegOffsetX: off_q[0] <= pwdata[OffsetBits-1:0];
        RegOffsetY: off_q[1] <= pwdata[OffsetBits-1:0];
        RegOffsetZ: off_q[2] <= pwdata[OffsetBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegOffsetX: prdata = 32'(off_q[0]);
      RegOffsetY: prdata = 32'(off_q[1]);
      RegOffsetZ: prdata = 32'(off_q[2]);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input split: coordinate plus offset into lattice cell and fraction
  // --------------------------------------------------------------------------
  logic        in_xfer;
  logic        in_load;
  logic [31:0] coord [3];
  logic [32:0] sum   [3];

  assign coord[0] = s_axis_tdata[31:0];
  assign coord[1] = s_axis_tdata[63:32];
  assign coord[2] = s_axis_tdata[95:64];

  for (genvar i = 0; i < 3; i++) begin : g_split
    assign sum[i] = {coord[i][31], coord[i]} + {9'b0, off_q[i]};
  end

  assign in_xfer = s_axis_tvalid & s_axis_tready;
  assign in_load = s_axis_tuser[0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  fsm_e  fsm_q, fsm_d;
  step_e step_q, step_d;
  logic  out_valid_q, out_valid_d;
  logic  out_load;

  assign s_axis_tready = (fsm_q == FSM_IDLE);
  assign out_load      = (fsm_q == FSM_RUN) && (step_q == STP_DONE)
                         && (!out_valid_q || m_axis_tready);

  always_comb begin
    fsm_d       = fsm_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (fsm_q)
      FSM_IDLE: begin
        if (in_xfer && !in_load) begin
          fsm_d  = FSM_RUN;
          step_d = STP_X2;
        end
      end
      FSM_RUN: begin
        if (step_q == STP_DONE) begin
          // hold here until the output register frees up
          if (out_load) begin
            fsm_d       = FSM_IDLE;
            out_valid_d = 1'b1;
          end
        end else begin
          step_d = step_e'(step_q + 5'd1);
        end
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      step_q      <= STP_X2;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Working registers
  // --------------------------------------------------------------------------
  logic [CellBits-1:0]  cell_q [3];
  logic [FRAC_BITS-1:0] frac_q [3];
  logic [CellBits-1:0]  ha_q, hb_q, haa_q, hab_q, hba_q, hbb_q;
  logic signed [W-1:0]  sq_q   [3];   // t^2
  logic signed [W-1:0]  inr_q  [3];   // t*(6t-15)+10
  logic signed [W-1:0]  cube_q [3];   // t^3
  logic signed [W-1:0]  fade_q [3];   // u, v, w
  logic signed [W-1:0]  g_q    [8];   // corner gradients, index = {z1,y1,x1}
  logic signed [W-1:0]  lv_q   [6];   // lerp results

  // Corner coordinates: near side t, far side t-1
  logic signed [W-1:0] pos [3];
  logic signed [W-1:0] neg [3];
  logic signed [W-1:0] inr_op [3];

  for (genvar i = 0; i < 3; i++) begin : g_corner
    assign pos[i]    = $signed({{(W-FRAC_BITS){1'b0}}, frac_q[i]});
    assign neg[i]    = pos[i] - OneFx;
    assign inr_op[i] = (pos[i] <<< 2) + (pos[i] <<< 1) - C15Fx;
  end

  // --------------------------------------------------------------------------
  // Permutation table
  // --------------------------------------------------------------------------
  logic                ram_we;
  logic [CellBits-1:0] ram_addr;
  logic [CellBits-1:0] ram_q;

  assign ram_we = in_xfer & in_load;

  always_comb begin
    ram_addr = s_axis_tdata[103:96];
    if (fsm_q == FSM_RUN) begin
      case (step_q)
        STP_X2:  ram_addr = cell_q[0];
        STP_Y2:  ram_addr = cell_q[0] + 8'd1;
        STP_Z2:  ram_addr = ha_q;
        STP_XI:  ram_addr = ha_q + 8'd1;
        STP_YI:  ram_addr = hb_q;
        STP_ZI:  ram_addr = hb_q + 8'd1;
        STP_X3:  ram_addr = haa_q;
        STP_Y3:  ram_addr = haa_q + 8'd1;
        STP_Z3:  ram_addr = hba_q;
        STP_FX:  ram_addr = hba_q + 8'd1;
        STP_FY:  ram_addr = hab_q;
        STP_FZ:  ram_addr = hab_q + 8'd1;
        STP_L0:  ram_addr = hbb_q;
        STP_L2:  ram_addr = hbb_q + 8'd1;
        default: ram_addr = hbb_q;
      endcase
    end
  end

  ipn_ram #(
    .Width (CellBits),
    .Depth (256)
  ) u_perm (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (s_axis_tdata[111:104]),
    .rdata_o (ram_q)
  );

  // --------------------------------------------------------------------------
  // Shared multiplier: operand select per step
  // --------------------------------------------------------------------------
  logic                mul_en;
  logic signed [W-1:0] mul_a, mul_b, mul_p;

  always_comb begin
    mul_en = (fsm_q == FSM_RUN);
    mul_a  = pos[0];
    mul_b  = pos[0];
    case (step_q)
      STP_X2: begin mul_a = pos[0];    mul_b = pos[0];            end
      STP_Y2: begin mul_a = pos[1];    mul_b = pos[1];            end
      STP_Z2: begin mul_a = pos[2];    mul_b = pos[2];            end
      STP_XI: begin mul_a = pos[0];    mul_b = inr_op[0];         end
      STP_YI: begin mul_a = pos[1];    mul_b = inr_op[1];         end
      STP_ZI: begin mul_a = pos[2];    mul_b = inr_op[2];         end
      STP_X3: begin mul_a = sq_q[0];   mul_b = pos[0];            end
      STP_Y3: begin mul_a = sq_q[1];   mul_b = pos[1];            end
      STP_Z3: begin mul_a = sq_q[2];   mul_b = pos[2];            end
      STP_FX: begin mul_a = cube_q[0]; mul_b = inr_q[0];          end
      STP_FY: begin mul_a = cube_q[1]; mul_b = inr_q[1];          end
      STP_FZ: begin mul_a = cube_q[2]; mul_b = inr_q[2];          end
      STP_L0: begin mul_a = fade_q[0]; mul_b = g_q[1] - g_q[0];   end
      STP_L2: begin mul_a = fade_q[0]; mul_b = g_q[5] - g_q[4];   end
      STP_L1: begin mul_a = fade_q[0]; mul_b = g_q[3] - g_q[2];   end
      STP_L3: begin mul_a = fade_q[0]; mul_b = g_q[7] - g_q[6];   end
      STP_L4: begin mul_a = fade_q[1]; mul_b = lv_q[1] - lv_q[0]; end
      STP_L5: begin mul_a = fade_q[1]; mul_b = lv_q[3] - lv_q[2]; end
      STP_L6: begin mul_a = fade_q[2]; mul_b = lv_q[5] - lv_q[4]; end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  ipn_mul #(
    .Width    (W),
    .FracBits (FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // --------------------------------------------------------------------------
  // Write-back: each step stores the previous cycle's product and table read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer && !in_load) begin
      for (int i = 0; i < 3; i++) begin
        cell_q[i] <= sum[i][FRAC_BITS +: CellBits];
        frac_q[i] <= sum[i][FRAC_BITS-1:0];
      end
    end
    if (fsm_q == FSM_RUN) begin
      case (step_q)
        STP_Y2: begin
          sq_q[0] <= mul_p;
          ha_q    <= ram_q + cell_q[1];
        end
        STP_Z2: begin
          sq_q[1] <= mul_p;
          hb_q    <= ram_q + cell_q[1];
        end
        STP_XI: begin
          sq_q[2] <= mul_p;
          haa_q   <= ram_q + cell_q[2];
        end
        STP_YI: begin
          inr_q[0] <= mul_p + C10Fx;
          hab_q    <= ram_q + cell_q[2];
        end
        STP_ZI: begin
          inr_q[1] <= mul_p + C10Fx;
          hba_q    <= ram_q + cell_q[2];
        end
        STP_X3: begin
          inr_q[2] <= mul_p + C10Fx;
          hbb_q    <= ram_q + cell_q[2];
        end
        STP_Y3: begin
          cube_q[0] <= mul_p;
          g_q[0]    <= grad(ram_q[3:0], pos[0], pos[1], pos[2]);
        end
        STP_Z3: begin
          cube_q[1] <= mul_p;
          g_q[4]    <= grad(ram_q[3:0], pos[0], pos[1], neg[2]);
        end
        STP_FX: begin
          cube_q[2] <= mul_p;
          g_q[1]    <= grad(ram_q[3:0], neg[0], pos[1], pos[2]);
        end
        STP_FY: begin
          fade_q[0] <= mul_p;
          g_q[5]    <= grad(ram_q[3:0], neg[0], pos[1], neg[2]);
        end
        STP_FZ: begin
          fade_q[1] <= mul_p;
          g_q[2]    <= grad(ram_q[3:0], pos[0], neg[1], pos[2]);
        end
        STP_L0: begin
          fade_q[2] <= mul_p;
          g_q[6]    <= grad(ram_q[3:0], pos[0], neg[1], neg[2]);
        end
        STP_L2: begin
          lv_q[0] <= g_q[0] + mul_p;
          g_q[3]  <= grad(ram_q[3:0], neg[0], neg[1], pos[2]);
        end
        STP_L1: begin
          lv_q[2] <= g_q[4] + mul_p;
          g_q[7]  <= grad(ram_q[3:0], neg[0], neg[1], neg[2]);
        end
        STP_L3:  lv_q[1] <= g_q[2] + mul_p;
        STP_L4:  lv_q[3] <= g_q[6] + mul_p;
        STP_L5:  lv_q[4] <= lv_q[0] + mul_p;
        STP_GAP: lv_q[5] <= lv_q[2] + mul_p;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Final blend, rescale to 16 fraction bits with floor, saturate
  // --------------------------------------------------------------------------
  logic signed [W-1:0]  res;
  logic signed [RW-1:0] res_q16;
  logic [17:0]          noise_d;
  logic [17:0]          noise_q;

  assign res     = lv_q[4] + mul_p;
  assign res_q16 = $signed({res, 16'b0}) >>> FRAC_BITS;

  always_comb begin
    if (res_q16 > RW'(OutMax)) begin
      noise_d = 18'(OutMax);
    end else if (res_q16 < RW'(OutMin)) begin
      noise_d = 18'(OutMin);
    end else begin
      noise_d = res_q16[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      noise_q <= noise_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, noise_q};

endmodule
`default_nettype wire
